// ----- hw/rtl/mrwt_pkg.sv -----
// mrwt_pkg: shared types and constants for the Miller-Rabin witness test.
// No dependencies.
package mrwt_pkg;

  localparam int unsigned MRWT_WIDTH = 64;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STRIP,
    ST_RED,
    ST_PSTEP,
    ST_PWAIT,
    ST_SQCHK,
    ST_SQWAIT,
    ST_DONE
  } mrwt_state_t;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_MOD
  } mrwt_op_t;

  typedef struct packed {
    logic     go;
    mrwt_op_t op;
  } mrwt_cmd_t;

endpackage

// ----- hw/rtl/mrwt_mulmod.sv -----
// mrwt_mulmod: serial modular unit, (x*y) mod m by shift-and-add, or y mod m by
// shift-subtract. One bit per cycle. Depends on mrwt_pkg.
module mrwt_mulmod import mrwt_pkg::*; #(
  parameter int unsigned WIDTH = MRWT_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  mrwt_cmd_t        cmd,
  input  logic [WIDTH-2:0] x,
  input  logic [WIDTH-2:0] y,
  input  logic [WIDTH-2:0] m,
  output logic             done,
  output logic [WIDTH-2:0] res
);

  localparam int unsigned VW = WIDTH - 1;
  localparam int unsigned CW = $clog2(VW + 1);

  logic             busy;
  mrwt_op_t         op;
  logic [VW-1:0]    acc;
  logic [VW-1:0]    xs;
  logic [VW-1:0]    ys;
  logic [VW-1:0]    mm;
  logic [CW-1:0]    cnt;

  logic [VW:0]      sum_ax;
  logic [VW-1:0]    acc_add;
  logic [VW:0]      sum_xx;
  logic [VW-1:0]    x_dbl;
  logic [VW:0]      rem_sh;
  logic [VW-1:0]    rem_red;

  always_comb begin
    sum_ax  = {1'b0, acc} + {1'b0, xs};
    acc_add = (sum_ax >= {1'b0, mm}) ? VW'(sum_ax - {1'b0, mm}) : sum_ax[VW-1:0];
    sum_xx  = {xs, 1'b0};
    x_dbl   = (sum_xx >= {1'b0, mm}) ? VW'(sum_xx - {1'b0, mm}) : sum_xx[VW-1:0];
    rem_sh  = {acc, ys[VW-1]};
    rem_red = (rem_sh >= {1'b0, mm}) ? VW'(rem_sh - {1'b0, mm}) : rem_sh[VW-1:0];
  end

  assign res = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.go) begin
        busy <= 1'b1;
        op   <= cmd.op;
        acc  <= '0;
        xs   <= x;
        ys   <= y;
        mm   <= m;
        cnt  <= CW'(VW);
      end else if (busy) begin
        if (op == OP_MUL) begin
          if (ys[0]) acc <= acc_add;
          xs <= x_dbl;
          ys <= ys >> 1;
        end else begin
          acc <= rem_red;
          ys  <= ys << 1;
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/miller_rabin_witness_test.sv -----
// miller_rabin_witness_test: one Miller-Rabin round for a candidate and a base.
// Depends on mrwt_pkg and mrwt_mulmod.
//
//  channel  | ports                          | handshake
//  ---------+--------------------------------+------------------------
//  request  | candidate, witness_base        | start && !busy
//  result   | probable_prime                 | done, one cycle, no stall
//
// Cost: every modular product or reduction runs on the one serial unit. An odd
// candidate costs one reduction, up to 2*(WIDTH-2) products for the power and up
// to WIDTH-2 squarings. Trivial candidates (even or below 3) go straight to done
// without the unit.
// Reset is synchronous and clears the sequencer; busy is high from the cycle
// after accept and drops in the cycle of done, so the next request can be
// taken while done is up. The receiver cannot stall the result.
module miller_rabin_witness_test import mrwt_pkg::*; #(
  parameter int unsigned WIDTH = MRWT_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [WIDTH-2:0] candidate,
  input  logic [WIDTH-2:0] witness_base,
  output logic             done,
  output logic             probable_prime
);

  localparam int unsigned VW = WIDTH - 1;

  mrwt_state_t   state, state_next;
  logic [VW-1:0] n, nm1, d, e, b, acc, t;
  logic          sel_b;       // power step: 0 = acc*b, 1 = b*b
  logic          verdict;

  mrwt_cmd_t     cmd;
  logic [VW-1:0] ux, uy;
  logic          udone;
  logic [VW-1:0] ures;

  mrwt_mulmod #(.WIDTH(WIDTH)) u_mm (
    .clk(clk), .rst(rst), .cmd(cmd), .x(ux), .y(uy), .m(n),
    .done(udone), .res(ures)
  );

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (accept) begin
        if (candidate < VW'(3) || !candidate[0]) state_next = ST_DONE;
        else state_next = ST_STRIP;
      end
      ST_STRIP:  if (d[0]) state_next = ST_RED;
      ST_RED:    if (udone) state_next = ST_PSTEP;
      ST_PSTEP:  state_next = (e == '0 && !sel_b) ? ST_SQCHK : ST_PWAIT;
      ST_PWAIT:  if (udone) state_next = ST_PSTEP;
      ST_SQCHK:  state_next = (d == nm1 || t == VW'(1) || t == nm1) ? ST_DONE : ST_SQWAIT;
      ST_SQWAIT: if (udone) state_next = ST_SQCHK;
      ST_DONE:   state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // unit commands
  always_comb begin
    cmd.go = 1'b0;
    cmd.op = OP_MUL;
    ux     = acc;
    uy     = b;
    case (state)
      ST_STRIP: begin
        cmd.go = d[0];
        cmd.op = OP_MOD;
        ux     = '0;
        uy     = b;
      end
      ST_PSTEP: begin
        cmd.go = !(e == '0 && !sel_b);
        // clear exponent bit: go straight to the square of b
        ux     = (sel_b || !e[0]) ? b : acc;
      end
      ST_SQCHK: begin
        cmd.go = !(d == nm1 || t == VW'(1) || t == nm1);
        ux     = t;
        uy     = t;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_DONE);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: if (accept) begin
        n       <= candidate;
        nm1     <= candidate - 1'b1;
        d       <= candidate - 1'b1;
        b       <= witness_base;
        acc     <= VW'(1);
        sel_b   <= 1'b0;
        verdict <= (candidate == VW'(2));
      end
      ST_STRIP: begin
        if (!d[0]) d <= d >> 1;
        else e <= d;
      end
      ST_RED: if (udone) b <= ures;
      ST_PSTEP: begin
        // skip the multiply by b where the exponent bit is clear
        if (!sel_b && !e[0] && e != '0) sel_b <= 1'b1;
        if (e == '0 && !sel_b) t <= acc;
      end
      ST_PWAIT: if (udone) begin
        if (sel_b) begin
          b     <= ures;
          e     <= e >> 1;
          sel_b <= 1'b0;
        end else begin
          acc   <= ures;
          sel_b <= 1'b1;
        end
      end
      ST_SQCHK: if (d == nm1 || t == VW'(1) || t == nm1)
        verdict <= (t == nm1) || d[0];
      ST_SQWAIT: if (udone) begin
        t <= ures;
        d <= d << 1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) probable_prime <= verdict;

endmodule

// ----- tb/tb_top.sv -----
// tb_top: self-checking bench for miller_rabin_witness_test, one Miller-Rabin round.
// Depends on mrwt_pkg and the miller_rabin_witness_test RTL.
`timescale 1ns / 1ps

module tb_top;
  import mrwt_pkg::*;

  localparam int unsigned W = MRWT_WIDTH;
  localparam int unsigned WATCHDOG_CYCLES = 200000;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           start = 1'b0;
  logic           busy;
  logic [W-2:0]   candidate = '0;
  logic [W-2:0]   witness_base = '0;
  logic           done;
  logic           probable_prime;

  // verdicts still owed by the block, oldest first
  bit             verdict_queue[$];
  int             n_errors = 0;
  int             idle_cycles = 0;

  always #1 clk = ~clk;

  miller_rabin_witness_test dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .candidate(candidate), .witness_base(witness_base),
    .done(done), .probable_prime(probable_prime)
  );

  // ---------------- predictor ----------------
  // exact (x*y) mod m via the double-width product
  function automatic logic [W-2:0] mulmod(logic [W-2:0] x, logic [W-2:0] y,
                                          logic [W-2:0] m);
    logic [2*W-1:0] p;
    p = {{(W+1){1'b0}}, x} * {{(W+1){1'b0}}, y};
    return (W-1)'(p % {{(W+1){1'b0}}, m});
  endfunction

  function automatic bit mr_verdict(logic [W-2:0] n, logic [W-2:0] a);
    logic [W-2:0] nm1, d, t, b, e;
    if (n < 2) return 1'b0;
    if (n == 2) return 1'b1;
    if (!n[0]) return 1'b0;
    nm1 = n - 1;
    d = nm1;
    while (!d[0]) d = d >> 1;
    // square-and-multiply for a^d mod n
    b = a % n;
    e = d;
    t = (W-1)'(1);
    while (e != 0) begin
      if (e[0]) t = mulmod(t, b, n);
      e = e >> 1;
      b = mulmod(b, b, n);
    end
    // squaring chain: stop at 1, n-1, or once d is back to n-1
    while (d != nm1 && t != 1 && t != nm1) begin
      t = mulmod(t, t, n);
      d = d << 1;
    end
    return (t == nm1) || d[0];
  endfunction

  // ---------------- result checker ----------------
  // done is a one-cycle strobe; no back-pressure, so sample every edge
  always @(posedge clk) begin
    if (!rst && done) begin
      if (verdict_queue.size() == 0) begin
        $error("probable_prime: result with no request pending (actual %0d)",
               probable_prime);
        n_errors++;
      end else begin
        bit exp_v;
        exp_v = verdict_queue.pop_front();
        if (probable_prime !== exp_v) begin
          $error("probable_prime: expected %0d actual %0d", exp_v, probable_prime);
          n_errors++;
        end
      end
    end
  end

  // watchdog: cycles with nothing accepted on either side
  always @(posedge clk) begin
    if ((start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  bit no_gaps = 1'b0;

  // send one request; prediction is queued at the accepting edge.
  // start stays high after accept and is dropped only for an idle gap,
  // so back-to-back requests never drive start twice in one step.
  task automatic send_request(logic [W-2:0] n, logic [W-2:0] a);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    candidate    <= n;
    witness_base <= a;
    start        <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    verdict_queue.push_back(mr_verdict(n, a));
  endtask

  function automatic logic [W-2:0] rand_word();
    return (W-1)'({$urandom, $urandom});
  endfunction

  task automatic test_trivial_candidates();
    send_request(0, 5);
    send_request(1, 0);
    send_request(2, 7);
    send_request(4, 3);
    send_request('1 - 1, '1);          // largest even
    send_request(3, 0);                // candidate 3, all residues of base
    send_request(3, 1);
    send_request(3, 2);
    send_request(3, '1);
  endtask

  task automatic test_special_bases();
    logic [W-2:0] p;
    p = 63'd1000000007;
    send_request(p, 0);                // base multiple of n
    send_request(p, p * 5);
    send_request(p, 1);                // base congruent to 1
    send_request(p, p - 1);            // base congruent to n-1
    send_request(p, p + 1);
    send_request('1, '1);              // all ones both fields
    send_request('1, 2);
    send_request(63'd561, 2);          // Carmichael
    send_request(63'd2047, 2);         // strong pseudoprime to base 2
    send_request(63'd4611686018427387847, 3); // large prime just below 2^62
    send_request(63'h7FFF_FFFF_FFFF_FFE7, 2);
  endtask

  task automatic test_random_items();
    logic [W-2:0] n;
    for (int i = 0; i < 100; i++) begin
      no_gaps = (i >= 40 && i < 55);   // a stretch with back-to-back requests
      case ($urandom_range(0, 3))
        0: n = rand_word();
        1: n = rand_word() | 1;
        2: n = rand_word() >> $urandom_range(0, 60);
        default: n = (rand_word() >> $urandom_range(40, 60)) | 1;
      endcase
      send_request(n, $urandom_range(0, 1) ? rand_word()
                                           : (W-1)'($urandom_range(2, 50)));
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_trivial_candidates();
    test_special_bases();
    test_random_items();
    start <= 1'b0;
    while (verdict_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (n_errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/mrwt_pkg.sv
hw/rtl/mrwt_mulmod.sv
hw/rtl/miller_rabin_witness_test.sv
tb/tb_top.sv
